FILE: rtl/bba_pkg.sv
// shared types, constants and helper functions of the bitmap block allocator
`default_nettype none

package bba_pkg;

    localparam int NUM_BLOCKS    = 4096;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_DEPTH     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ADDR_W        = $clog2(MAP_DEPTH);
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
    localparam int BLK_W         = 12;
    localparam int LIM_W         = 13;
    localparam int WORD_W        = LIM_W - BIT_IDX_W;
    localparam int CFG_IDX_W     = 1;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;

    typedef enum logic [1:0] {
        REQ_ALLOC_ZERO = 2'd0,
        REQ_ALLOC      = 2'd1,
        REQ_FREE       = 2'd2,
        REQ_TEST       = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_BLOCK = 2'd1,
        ST_NO_SPACE  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_BLOCK    = 1'd0,
        CFG_DEVICE_BLOCKS = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [BLK_W-1:0] block_number;
        logic             txn_active;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] chosen_block;
        logic             bit_was_set;
        logic             zero_needed;
        logic             discard_now;
        logic             discard_deferred;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        map_word_t         wr_data;
    } mem_req_t;

    // bits of a map word whose block numbers lie in [lo, hi)
    function automatic map_word_t range_mask(input logic [WORD_W-1:0] word,
                                             input logic [LIM_W-1:0]  lo,
                                             input logic [LIM_W-1:0]  hi);
        map_word_t lo_part;
        map_word_t hi_part;
        logic [WORD_W-1:0]    lo_w;
        logic [WORD_W-1:0]    hi_w;
        logic [BIT_IDX_W-1:0] lo_b;
        logic [BIT_IDX_W-1:0] hi_b;
        lo_w = lo[LIM_W-1:BIT_IDX_W];
        hi_w = hi[LIM_W-1:BIT_IDX_W];
        lo_b = lo[BIT_IDX_W-1:0];
        hi_b = hi[BIT_IDX_W-1:0];
        if (word > lo_w)
            lo_part = '1;
        else if (word == lo_w)
            lo_part = map_word_t'('1) << lo_b;
        else
            lo_part = '0;
        if (word < hi_w)
            hi_part = '1;
        else if (word == hi_w)
            hi_part = ~(map_word_t'('1) << hi_b);
        else
            hi_part = '0;
        return lo_part & hi_part;
    endfunction

    // index of the lowest set bit
    function automatic logic [BIT_IDX_W-1:0] first_set(input map_word_t m);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (m[i])
                idx = BIT_IDX_W'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bba_map_mem.sv
// bitmap word memory with per-row valid bits so reset reads as all free
`default_nettype none

module bba_map_mem
    import bba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mem_req_t  mem_req,
    output map_word_t      rd_data
);

    map_word_t            map_ram [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] row_valid_reg;
    map_word_t            rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
            map_ram[mem_req.wr_addr] <= mem_req.wr_data;
        if (mem_req.rd_en)
            rd_data_reg <= map_ram[mem_req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
                row_valid_reg[mem_req.wr_addr] <= 1'b1;
            if (mem_req.rd_en)
                rd_valid_reg <= row_valid_reg[mem_req.rd_addr];
        end
    end

    // a row never written is all free
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/bba_ctrl.sv
// request sequencer: next-fit scan, free and test over the map memory
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [BLK_W-1:0] base_block,
    input  wire logic [LIM_W-1:0] limit,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire req_t             req,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output result_t               res,
    output mem_req_t              mem_req,
    input  wire map_word_t        rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FREE,
        S_TEST,
        S_DONE
    } state_t;

    state_t            state_reg,     state_next;
    req_t              req_reg,       req_next;
    logic [LIM_W-1:0]  hint_reg,      hint_next;
    logic              phase_reg,     phase_next;
    logic [LIM_W-1:0]  lo_reg,        lo_next;
    logic [LIM_W-1:0]  hi_reg,        hi_next;
    logic [WORD_W-1:0] rd_word_reg,   rd_word_next;
    logic [WORD_W-1:0] chk_word_reg,  chk_word_next;
    logic              chk_valid_reg, chk_valid_next;
    result_t           res_reg,       res_next;

    logic [LIM_W-1:0]     ds_ext;
    logic [LIM_W-1:0]     blk_ext;
    logic [LIM_W-1:0]     start_blk;
    logic                 issue_ok;
    map_word_t            scan_mask;
    logic [BIT_IDX_W-1:0] hit_idx;
    logic [LIM_W-1:0]     found;
    logic [ADDR_W-1:0]    blk_addr;

    assign ds_ext    = {1'b0, base_block};
    assign blk_ext   = {1'b0, req_reg.block_number};
    assign blk_addr  = req_reg.block_number[BIT_IDX_W +: ADDR_W];
    // out-of-range hint restarts the scan at base_block
    assign start_blk = (hint_reg < ds_ext || hint_reg >= limit) ? ds_ext : hint_reg;
    assign issue_ok  = {rd_word_reg, {BIT_IDX_W{1'b0}}} < hi_reg;
    assign scan_mask = ~rd_data & range_mask(chk_word_reg, lo_reg, hi_reg);
    assign hit_idx   = first_set(scan_mask);
    assign found     = {chk_word_reg, hit_idx};

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        hint_next      = hint_reg;
        phase_next     = phase_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rd_word_next   = rd_word_reg;
        chk_word_next  = chk_word_reg;
        chk_valid_next = chk_valid_reg;
        res_next       = res_reg;
        mem_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    res_next   = '0;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                case (req_reg.req_type)
                    REQ_ALLOC_ZERO, REQ_ALLOC:
                    begin
                        if (start_blk >= limit)
                        begin
                            res_next.status = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            phase_next     = 1'b0;
                            lo_next        = start_blk;
                            hi_next        = limit;
                            rd_word_next   = start_blk[LIM_W-1:BIT_IDX_W];
                            chk_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (blk_ext < ds_ext || blk_ext >= limit)
                        begin
                            res_next.status = ST_BAD_BLOCK;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = blk_addr;
                            state_next      = S_FREE;
                        end
                    end
                    default:
                    begin
                        // test beyond the map reads as free
                        if (blk_ext >= LIM_W'(NUM_BLOCKS))
                            state_next = S_DONE;
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = blk_addr;
                            state_next      = S_TEST;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                // one word read per cycle, checked in the cycle after its read
                mem_req.rd_en   = issue_ok;
                mem_req.rd_addr = rd_word_reg[ADDR_W-1:0];
                rd_word_next    = rd_word_reg + WORD_W'(1);
                chk_word_next   = rd_word_reg;
                chk_valid_next  = issue_ok;
                if (chk_valid_reg && scan_mask != '0)
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = chk_word_reg[ADDR_W-1:0];
                    mem_req.wr_data      = rd_data | (map_word_t'(1) << hit_idx);
                    hint_next            = found + LIM_W'(1);
                    res_next.chosen_block = found[BLK_W-1:0];
                    res_next.zero_needed = (req_reg.req_type == REQ_ALLOC_ZERO);
                    state_next           = S_DONE;
                end
                else if (!issue_ok)
                begin
                    // range exhausted: wrap once to [base_block, start)
                    if (!phase_reg && lo_reg > ds_ext)
                    begin
                        phase_next     = 1'b1;
                        hi_next        = lo_reg;
                        lo_next        = ds_ext;
                        rd_word_next   = ds_ext[LIM_W-1:BIT_IDX_W];
                        chk_valid_next = 1'b0;
                    end
                    else
                    begin
                        res_next.status = ST_NO_SPACE;
                        state_next      = S_DONE;
                    end
                end
            end

            S_FREE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = blk_addr;
                mem_req.wr_data = rd_data &
                    ~(map_word_t'(1) << req_reg.block_number[BIT_IDX_W-1:0]);
                if (blk_ext < hint_reg)
                    hint_next = blk_ext;
                res_next.discard_deferred = req_reg.txn_active;
                res_next.discard_now      = ~req_reg.txn_active;
                state_next = S_DONE;
            end

            S_TEST:
            begin
                res_next.bit_was_set = rd_data[req_reg.block_number[BIT_IDX_W-1:0]];
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            hint_reg      <= '0;
            phase_reg     <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            rd_word_reg   <= '0;
            chk_word_reg  <= '0;
            chk_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            hint_reg      <= hint_next;
            phase_reg     <= phase_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            rd_word_reg   <= rd_word_next;
            chk_word_reg  <= chk_word_next;
            chk_valid_reg <= chk_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bitmap_block_allocator.sv
// top level of the next-fit bitmap block allocator
`default_nettype none

// Next-fit block allocator over a used/free bitmap of NUM_BLOCKS blocks, held
// as MAP_WORD_BITS-bit words in a single-port-read, single-port-write memory
// with a registered read port. Requests are handled one at a time: an
// allocation (zeroed or not) scans map words from the next-fit hint up to
// min(device block count, NUM_BLOCKS), then wraps from the base block up to
// the hint, marks the first free block used and returns it; a free
// range-checks the block, clears its bit, lowers the hint and reports an
// immediate or deferred discard; a test reads one bit. A scan reads one map
// word (32 blocks) per cycle. The result sits in an output register, so the
// next request can be accepted the cycle after the result enters it, while
// the previous result waits to be taken. The map needs no clearing pass after
// reset: one valid bit per memory row marks rows that were never written, and
// those read as all free. Configuration (base block, device block count) must
// only be written while no request is in flight.

module bitmap_block_allocator
    import bba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           req_type,
    input  wire logic [BLK_W-1:0]     block_number,
    input  wire logic                 txn_active,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [BLK_W-1:0]          chosen_block,
    output logic                      bit_was_set,
    output logic                      zero_needed,
    output logic                      discard_now,
    output logic                      discard_deferred,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIM_W-1:0]     cfg_data
);

    logic [BLK_W-1:0] base_block_reg;
    logic [LIM_W-1:0] device_blocks_reg;
    logic [LIM_W-1:0] limit;

    logic     out_valid_reg;
    result_t  out_reg;

    req_t      req;
    logic      res_valid;
    logic      res_ready;
    result_t   res;
    mem_req_t  mem_req;
    map_word_t rd_data;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_block_reg    <= '0;
            device_blocks_reg <= LIM_W'(4096);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE_BLOCK:    base_block_reg    <= cfg_data[BLK_W-1:0];
                CFG_DEVICE_BLOCKS: device_blocks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // effective upper limit of allocatable blocks
    assign limit = (device_blocks_reg < LIM_W'(NUM_BLOCKS)) ? device_blocks_reg
                                                            : LIM_W'(NUM_BLOCKS);

    assign req.req_type     = req_type;
    assign req.block_number = block_number;
    assign req.txn_active   = txn_active;

    bba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_block (base_block_reg),
        .limit      (limit),
        .req_valid  (in_valid),
        .req_ready  (in_ready),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    bba_map_mem u_map_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // output register decouples the sequencer from the result consumer
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
                out_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_reg.status;
    assign chosen_block     = out_reg.chosen_block;
    assign bit_was_set      = out_reg.bit_was_set;
    assign zero_needed      = out_reg.zero_needed;
    assign discard_now      = out_reg.discard_now;
    assign discard_deferred = out_reg.discard_deferred;

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // a result reports at most one kind of side effect
    a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({bit_was_set, zero_needed, discard_now,
                                  discard_deferred}) <= 1)
        else $error("result carries more than one side effect");

    // failed requests carry no block and no side effect
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |->
            chosen_block == '0 && !zero_needed && !discard_now && !discard_deferred)
        else $error("failed request reports a block or side effect");

    // a block allocated for zeroing lies inside the configured range
    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_needed |->
            chosen_block >= base_block_reg && {1'b0, chosen_block} < limit)
        else $error("allocated block outside the allocatable range");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench for the next-fit bitmap block allocator
`timescale 1ns / 100ps

module testbench;
    import bba_pkg::*;

    localparam int HALF_PERIOD       = 5;
    localparam int SETTLE_CYCLES     = 16;
    localparam int ITEMS_PER_SEGMENT = 40;
    localparam int TIMEOUT_NS        = 10_000_000;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic             in_valid     = 1'b0;
    logic             in_ready;
    logic [1:0]       req_type     = REQ_TEST;
    logic [BLK_W-1:0] block_number = '0;
    logic             txn_active   = 1'b0;

    // result channel
    logic             out_valid;
    logic             out_ready    = 1'b0;
    logic [1:0]       status;
    logic [BLK_W-1:0] chosen_block;
    logic             bit_was_set;
    logic             zero_needed;
    logic             discard_now;
    logic             discard_deferred;

    // configuration write channel
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE_BLOCK;
    logic [LIM_W-1:0]     cfg_data  = '0;

    // traffic shaping knobs, set by the test tasks
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic results_held = 1'b0;

    // predictor state: one used flag per block, the next-fit hint and the window
    bit               block_used [NUM_BLOCKS];
    int unsigned      alloc_hint   = 0;
    logic [BLK_W-1:0] window_first = '0;
    logic [LIM_W-1:0] window_limit = LIM_W'(4096);

    // results predicted for accepted requests, oldest first
    result_t awaited_results [$];
    result_t want;

    int errors          = 0;
    int n_checked       = 0;
    int n_alloc         = 0;
    int n_no_space      = 0;
    int n_free          = 0;
    int n_bad_free      = 0;
    int n_test          = 0;
    int n_window_writes = 0;

    bitmap_block_allocator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .block_number     (block_number),
        .txn_active       (txn_active),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .chosen_block     (chosen_block),
        .bit_was_set      (bit_was_set),
        .zero_needed      (zero_needed),
        .discard_now      (discard_now),
        .discard_deferred (discard_deferred),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // next-fit allocation, free and bit test against the predictor's own map
    function automatic result_t compute_allocator_result(input req_type_t kind,
                                                         input logic [BLK_W-1:0] blk,
                                                         input logic deferred);
        result_t     r;
        int unsigned lim;
        int unsigned start;
        int unsigned found;
        bit          hit;
        r     = '0;
        lim   = (window_limit < NUM_BLOCKS) ? window_limit : NUM_BLOCKS;
        hit   = 1'b0;
        found = 0;
        case (kind)
            REQ_ALLOC_ZERO, REQ_ALLOC:
            begin
                n_alloc++;
                // a hint outside the window restarts the scan at the window start
                start = alloc_hint;
                if (start < window_first || start >= lim)
                    start = window_first;
                // hint up to the limit first, then wrap from the window start
                for (int unsigned b = start; b < lim && !hit; b++)
                begin
                    if (!block_used[b])
                    begin
                        found = b;
                        hit   = 1'b1;
                    end
                end
                for (int unsigned b = window_first; b < start && !hit; b++)
                begin
                    if (!block_used[b])
                    begin
                        found = b;
                        hit   = 1'b1;
                    end
                end
                if (hit)
                begin
                    block_used[found] = 1'b1;
                    alloc_hint        = found + 1;
                    r.chosen_block    = BLK_W'(found);
                    r.zero_needed     = (kind == REQ_ALLOC_ZERO);
                end
                else
                begin
                    // empty window or every block taken: nothing changes
                    r.status = ST_NO_SPACE;
                    n_no_space++;
                end
            end
            REQ_FREE:
            begin
                n_free++;
                if (blk < window_first || blk >= lim)
                begin
                    r.status = ST_BAD_BLOCK;
                    n_bad_free++;
                end
                else
                begin
                    // freeing an already free block still reports the discard
                    if (blk < alloc_hint)
                        alloc_hint = blk;
                    block_used[blk]    = 1'b0;
                    r.discard_deferred = deferred;
                    r.discard_now      = !deferred;
                end
            end
            REQ_TEST:
            begin
                // no window check on a test
                n_test++;
                r.bit_was_set = block_used[blk];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string field_name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field_name, exp_val, act_val);
        end
    endfunction

    // one monitor for both channels and the config port so updates keep their order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request waiting, status %0d block %0d",
                             $time, status, chosen_block);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    n_checked++;
                    check_field("status", want.status, status);
                    check_field("chosen_block", want.chosen_block, chosen_block);
                    check_field("bit_was_set", want.bit_was_set, bit_was_set);
                    check_field("zero_needed", want.zero_needed, zero_needed);
                    check_field("discard_now", want.discard_now, discard_now);
                    check_field("discard_deferred", want.discard_deferred, discard_deferred);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BASE_BLOCK:    window_first = cfg_data[BLK_W-1:0];
                    CFG_DEVICE_BLOCKS: window_limit = cfg_data;
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
                awaited_results.push_back(compute_allocator_result(req_type_t'(req_type),
                                                                   block_number, txn_active));
        end
    end

    // result side: random stalls, or a solid hold-off while results_held is up
    always @(posedge clk)
    begin
        out_ready <= !results_held && ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one request after a random gap; valid stays up until accepted
    task automatic send_request(input req_type_t kind, input logic [BLK_W-1:0] blk,
                                input logic deferred);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        block_number <= blk;
        txn_active   <= deferred;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // random request aimed mostly inside the window [lo, top)
    task automatic send_random_request(input int unsigned lo, input int unsigned top);
        req_type_t        kind;
        logic [BLK_W-1:0] blk;
        int unsigned      pick;
        pick = $urandom_range(99);
        if (pick < 50)
            kind = $urandom_range(1) ? REQ_ALLOC_ZERO : REQ_ALLOC;
        else if (pick < 80)
            kind = REQ_FREE;
        else
            kind = REQ_TEST;
        pick = $urandom_range(99);
        if (pick < 5)
            blk = BLK_W'(top);      // just past the window
        else if (pick < 10)
            blk = BLK_W'(lo - 1);   // just below the window
        else if (pick < 85 && top > lo)
            blk = BLK_W'($urandom_range(lo, top - 1));
        else
            blk = BLK_W'($urandom_range(4095));
        send_request(kind, blk, 1'($urandom_range(1)));
    endtask

    // quiet the request side and let every outstanding result drain
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // write both window registers back to back, only while idle
    task automatic program_window(input int unsigned first_blk, input int unsigned limit);
        n_window_writes++;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BASE_BLOCK;
        cfg_data  <= LIM_W'(first_blk);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_DEVICE_BLOCKS;
        cfg_data  <= LIM_W'(limit);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic hold_result_port(input int cycles);
        results_held <= 1'b1;
        repeat (cycles)
            @(posedge clk);
        results_held <= 1'b0;
    endtask

    // hand-picked requests: every request type, window edges and corner cases
    task automatic test_directed_cases();
        send_idle_pct = 35;
        recv_idle_pct = 59;
        // reset window covers the whole device
        send_request(REQ_ALLOC_ZERO, 12'hfff, 1'b1);
        send_request(REQ_ALLOC, 12'h000, 1'b0);
        send_request(REQ_TEST, 12'd1, 1'b0);
        send_request(REQ_FREE, 12'd0, 1'b0);
        send_request(REQ_FREE, 12'd0, 1'b1);    // already free, discard still reported
        send_request(REQ_ALLOC, 12'd0, 1'b0);   // hint was lowered by the free
        wait_for_results();
        // single block at the top of the device, hint below the window
        program_window(4095, 4096);
        send_request(REQ_ALLOC, 12'd0, 1'b0);
        send_request(REQ_ALLOC_ZERO, 12'd0, 1'b0);
        send_request(REQ_FREE, 12'd4094, 1'b0);
        send_request(REQ_FREE, 12'd4095, 1'b1);
        wait_for_results();
        // start above the limit: nothing can be allocated or freed
        program_window(10, 5);
        send_request(REQ_ALLOC, 12'd0, 1'b1);
        send_request(REQ_FREE, 12'd10, 1'b0);
        send_request(REQ_TEST, 12'd1, 1'b0);    // tests ignore the window
        wait_for_results();
        // fill a small window, then open a hole below the hint
        program_window(8, 16);
        repeat (8)
            send_request(REQ_ALLOC, 12'd0, 1'b0);
        send_request(REQ_FREE, 12'd13, 1'b0);
        wait_for_results();
        // widen the window downward: second allocation has to wrap
        program_window(4, 16);
        send_request(REQ_ALLOC_ZERO, 12'd0, 1'b0);
        send_request(REQ_ALLOC, 12'd0, 1'b0);
        send_request(REQ_TEST, 12'd4, 1'b1);
        wait_for_results();
    endtask

    // random traffic in segments, each with a freshly chosen window
    task automatic test_random_mix(input int sender_gap_pct, input int receiver_stall_pct,
                                   input int segments);
        int unsigned lo;
        int unsigned hi;
        send_idle_pct = sender_gap_pct;
        recv_idle_pct = receiver_stall_pct;
        repeat (segments)
        begin
            wait_for_results();
            // small windows dominate so the map fills and wraps quickly
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    lo = $urandom_range(4095);
                    hi = lo + $urandom_range(1, 48);
                end
                4:
                begin
                    lo = $urandom_range(4095);
                    hi = lo + $urandom_range(49, 400);
                end
                5:
                begin
                    lo = 0;
                    hi = NUM_BLOCKS;
                end
                6:
                begin
                    lo = 0;
                    hi = $urandom_range(1, 40);
                end
                7:
                begin
                    lo = NUM_BLOCKS - 1;
                    hi = NUM_BLOCKS;
                end
                8:
                begin
                    // empty window
                    lo = $urandom_range(1, 4095);
                    hi = $urandom_range(1, lo);
                end
                default:
                begin
                    lo = $urandom_range(4000, 4095);
                    hi = NUM_BLOCKS;
                end
            endcase
            if (hi > NUM_BLOCKS)
                hi = NUM_BLOCKS;
            program_window(lo, hi);
            repeat (ITEMS_PER_SEGMENT)
                send_random_request(lo, hi);
        end
    endtask

    // result port held off while requests keep coming, so the input backs up
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_for_results();
        program_window(0, NUM_BLOCKS);
        fork
            hold_result_port(300);
            repeat (ITEMS_PER_SEGMENT)
                send_random_request(0, NUM_BLOCKS);
        join
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_mix(35, 59, 7);
        test_random_mix(59, 35, 7);
        test_random_mix(0, 0, 7);
        test_result_backpressure();
        wait_for_results();
        $display("checked %0d results: %0d allocations (%0d with no free block), %0d frees",
                 n_checked, n_alloc, n_no_space, n_free);
        $display("  (%0d outside the window), %0d bit tests, %0d window settings",
                 n_bad_free, n_test, n_window_writes);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #TIMEOUT_NS;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
